### rtl/core/perl_pkg.sv
package perl_pkg;

	localparam int FRAC_BITS = 16;
	localparam int TABLE_SIZE = 256;
	localparam int IDX_W = $clog2(TABLE_SIZE);
	localparam int ENT_W = 8;
	localparam int COORD_W = 24;
	localparam int NOISE_W = 16;
	localparam int HASH_W = 4;
	localparam int CORNERS = 8;

	// pipeline depth: item enters stage 1 on acceptance, result sits in the last stage
	localparam int N_STAGES = 8;
	// stages that own a copy of the permutation table
	localparam int TAB_STAGES = 3;

	localparam longint ONE_F = longint'(1) << FRAC_BITS;
	localparam longint HALF_F = longint'(1) << (FRAC_BITS - 1);
	localparam longint NOISE_MAX = (longint'(1) << NOISE_W) - 1;
	localparam longint OUT_SCALE = longint'(1) << (NOISE_W - 1);

	// fade polynomial coefficients
	localparam int FADE_C10 = 10;
	localparam int FADE_C15 = 15;
	localparam int FADE_C6 = 6;

	// gradient selection thresholds and special codes
	localparam logic [HASH_W-1:0] H_U_SPLIT = 4'd8;
	localparam logic [HASH_W-1:0] H_V_SPLIT = 4'd4;
	localparam logic [HASH_W-1:0] H_VX_A = 4'd12;
	localparam logic [HASH_W-1:0] H_VX_B = 4'd14;

	localparam int FADE_W = FRAC_BITS + 1;
	localparam int OFS_W = FRAC_BITS + 1;
	localparam int GRAD_W = FRAC_BITS + 3;
	localparam int LERP_W = FRAC_BITS + 4;

	typedef enum logic {
		OP_EVAL = 1'b0,
		OP_LOAD = 1'b1
	} op_t;

	typedef struct packed {
		logic [N_STAGES-1:0] adv;
		logic [TAB_STAGES-1:0] wr;
	} pipe_ctl_t;

	function automatic logic signed [GRAD_W-1:0] grad(input logic [HASH_W-1:0] h,
			input logic signed [OFS_W-1:0] x, input logic signed [OFS_W-1:0] y,
			input logic signed [OFS_W-1:0] z);
		logic signed [GRAD_W-1:0] u;
		logic signed [GRAD_W-1:0] v;
		u = (h < H_U_SPLIT) ? GRAD_W'(x) : GRAD_W'(y);
		if (h < H_V_SPLIT)
			v = GRAD_W'(y);
		else if (h == H_VX_A || h == H_VX_B)
			v = GRAD_W'(x);
		else
			v = GRAD_W'(z);
		if (h[0])
			u = -u;
		if (h[1])
			v = -v;
		return u + v;
	endfunction

	// a + round_half_up((b - a) * w / 2^F)
	function automatic logic signed [LERP_W-1:0] lerp(input logic [FADE_W-1:0] w,
			input logic signed [LERP_W-1:0] a, input logic signed [LERP_W-1:0] b);
		logic signed [LERP_W:0] d;
		logic signed [LERP_W+FRAC_BITS+2:0] p;
		logic signed [LERP_W+FRAC_BITS+2:0] r;
		d = {b[LERP_W-1], b} - {a[LERP_W-1], a};
		p = (LERP_W+FRAC_BITS+3)'(d) * (LERP_W+FRAC_BITS+3)'($signed({1'b0, w}));
		r = (p + (LERP_W+FRAC_BITS+3)'(HALF_F)) >>> FRAC_BITS;
		return a + r[LERP_W-1:0];
	endfunction

endpackage

### rtl/core/perlin_noise_3d_unit.sv
// Improved 3D Perlin gradient noise, one point per clock. Each coordinate is
// unsigned 8.16 fixed point; the lattice part wraps mod 256. An item with
// operation = 1 writes entry_value into the permutation table at entry_index
// and produces no result; an item with operation = 0 evaluates the noise and
// produces one noise_value, (n+1)/2 in Q0.16 saturated at 65535. All 256
// table entries must be loaded before the first evaluation. The block is an
// eight-stage pipeline: an item is taken every cycle while item_ready is high,
// and each result passes through stages 1 to 8 and is presented from the last
// stage, where it holds until noise_ready takes it. Stages 1
// to 3 read the table (lattice x, then y rows, then the eight corners) from
// replicated copies; a load walks through the same three stages and updates
// each copy at the point where evaluations read it, so loads and evaluations
// keep their order. The fade curves run alongside, and stages 4 to 8 take the
// gradients, the three lerp levels and the remap. Each stage moves on when it
// is empty or the stage after it moves, so bubbles close up under a stall.
module perlin_noise_3d_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              item_valid,
	output logic                              item_ready,
	input  logic                              operation,
	input  logic [perl_pkg::COORD_W-1:0]      coord_x,
	input  logic [perl_pkg::COORD_W-1:0]      coord_y,
	input  logic [perl_pkg::COORD_W-1:0]      coord_z,
	input  logic [perl_pkg::IDX_W-1:0]        entry_index,
	input  logic [perl_pkg::ENT_W-1:0]        entry_value,
	output logic                              noise_valid,
	input  logic                              noise_ready,
	output logic [perl_pkg::NOISE_W-1:0]      noise_value
);

	localparam int F = perl_pkg::FRAC_BITS;
	localparam int N = perl_pkg::N_STAGES;

	perl_pkg::pipe_ctl_t ctl;
	logic [N-1:0] vld;
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7, vld_s8;
	perl_pkg::op_t op_s1, op_s2, op_s3;
	perl_pkg::op_t op_in;

	logic [perl_pkg::CORNERS-1:0][perl_pkg::HASH_W-1:0] corner_hash_s3;
	logic [F-1:0] fx_s3, fy_s3, fz_s3;
	logic [perl_pkg::FADE_W-1:0] u_s4, v_s4, w_s4;

	assign op_in = perl_pkg::op_t'(operation);
	assign vld = {vld_s8, vld_s7, vld_s6, vld_s5, vld_s4, vld_s3, vld_s2, vld_s1};

	// advance a stage when it is empty or the next one advances
	always_comb begin
		ctl.adv[N-1] = !vld[N-1] || noise_ready;
		for (int k = N - 2; k >= 0; k--)
			ctl.adv[k] = !vld[k] || ctl.adv[k+1];
		// table copy writes follow the load down the first three stages
		ctl.wr[0] = item_valid && ctl.adv[0] && op_in == perl_pkg::OP_LOAD;
		ctl.wr[1] = vld_s1 && ctl.adv[1] && op_s1 == perl_pkg::OP_LOAD;
		ctl.wr[2] = vld_s2 && ctl.adv[2] && op_s2 == perl_pkg::OP_LOAD;
	end

	assign item_ready = ctl.adv[0];
	assign noise_valid = vld_s8;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
			vld_s8 <= 1'b0;
			op_s1 <= perl_pkg::OP_EVAL;
			op_s2 <= perl_pkg::OP_EVAL;
			op_s3 <= perl_pkg::OP_EVAL;
		end else begin
			if (ctl.adv[0]) begin
				vld_s1 <= item_valid;
				op_s1 <= op_in;
			end
			if (ctl.adv[1]) begin
				vld_s2 <= vld_s1;
				op_s2 <= op_s1;
			end
			if (ctl.adv[2]) begin
				vld_s3 <= vld_s2;
				op_s3 <= op_s2;
			end
			// drop loads here: they are done with the table
			if (ctl.adv[3])
				vld_s4 <= vld_s3 && op_s3 == perl_pkg::OP_EVAL;
			if (ctl.adv[4])
				vld_s5 <= vld_s4;
			if (ctl.adv[5])
				vld_s6 <= vld_s5;
			if (ctl.adv[6])
				vld_s7 <= vld_s6;
			if (ctl.adv[7])
				vld_s8 <= vld_s7;
		end
	end

	perl_hash u_hash (
		.clk(clk),
		.ctl(ctl),
		.lat_x(coord_x[F+perl_pkg::IDX_W-1:F]),
		.lat_y(coord_y[F+perl_pkg::IDX_W-1:F]),
		.lat_z(coord_z[F+perl_pkg::IDX_W-1:F]),
		.entry_index(entry_index),
		.entry_value(entry_value),
		.corner_hash_s3(corner_hash_s3)
	);

	perl_fade u_fade_x (
		.clk(clk), .ctl(ctl), .frac(coord_x[F-1:0]), .frac_s3(fx_s3), .fade_s4(u_s4)
	);

	perl_fade u_fade_y (
		.clk(clk), .ctl(ctl), .frac(coord_y[F-1:0]), .frac_s3(fy_s3), .fade_s4(v_s4)
	);

	perl_fade u_fade_z (
		.clk(clk), .ctl(ctl), .frac(coord_z[F-1:0]), .frac_s3(fz_s3), .fade_s4(w_s4)
	);

	perl_blend u_blend (
		.clk(clk),
		.ctl(ctl),
		.corner_hash_s3(corner_hash_s3),
		.fx_s3(fx_s3),
		.fy_s3(fy_s3),
		.fz_s3(fz_s3),
		.u_s4(u_s4),
		.v_s4(v_s4),
		.w_s4(w_s4),
		.noise_s8(noise_value)
	);

endmodule

### rtl/core/perl_ram.sv
module perl_ram #(
	parameter int ADDR_W = 8,
	parameter int DATA_W = 8
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [DATA_W-1:0] wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr0,
	input  logic [ADDR_W-1:0] raddr1,
	output logic [DATA_W-1:0] rdata0,
	output logic [DATA_W-1:0] rdata1
);

	logic [DATA_W-1:0] mem [2**ADDR_W];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		if (re) begin
			rdata0 <= mem[raddr0];
			rdata1 <= mem[raddr1];
		end
	end

endmodule

### rtl/core/perl_hash.sv
module perl_hash (
	input  logic                                           clk,
	input  perl_pkg::pipe_ctl_t                            ctl,
	input  logic [perl_pkg::IDX_W-1:0]                     lat_x,
	input  logic [perl_pkg::IDX_W-1:0]                     lat_y,
	input  logic [perl_pkg::IDX_W-1:0]                     lat_z,
	input  logic [perl_pkg::IDX_W-1:0]                     entry_index,
	input  logic [perl_pkg::ENT_W-1:0]                     entry_value,
	output logic [perl_pkg::CORNERS-1:0][perl_pkg::HASH_W-1:0] corner_hash_s3
);

	localparam int AW = perl_pkg::IDX_W;
	localparam int DW = perl_pkg::ENT_W;

	logic [AW-1:0] y_s1, z_s1, z_s2;
	logic [AW-1:0] idx_s1, idx_s2;
	logic [DW-1:0] val_s1, val_s2;
	logic [DW-1:0] px0_s1, px1_s1;
	logic [DW-1:0] pa0_s2, pa1_s2, pb0_s2, pb1_s2;
	logic [AW-1:0] addr_a, addr_b;
	logic [AW-1:0] base [4];
	logic [DW-1:0] lo_s3 [4];
	logic [DW-1:0] hi_s3 [4];

	// stage 1: row of x
	perl_ram #(.ADDR_W(AW), .DATA_W(DW)) u_tab_x (
		.clk(clk), .we(ctl.wr[0]), .waddr(entry_index), .wdata(entry_value),
		.re(ctl.adv[0]), .raddr0(lat_x), .raddr1(lat_x + AW'(1)),
		.rdata0(px0_s1), .rdata1(px1_s1)
	);

	always_ff @(posedge clk) begin
		if (ctl.adv[0]) begin
			y_s1 <= lat_y;
			z_s1 <= lat_z;
			idx_s1 <= entry_index;
			val_s1 <= entry_value;
		end
		if (ctl.adv[1]) begin
			z_s2 <= z_s1;
			idx_s2 <= idx_s1;
			val_s2 <= val_s1;
		end
	end

	// stage 2: rows of y
	assign addr_a = AW'(px0_s1) + y_s1;
	assign addr_b = AW'(px1_s1) + y_s1;

	perl_ram #(.ADDR_W(AW), .DATA_W(DW)) u_tab_ya (
		.clk(clk), .we(ctl.wr[1]), .waddr(idx_s1), .wdata(val_s1),
		.re(ctl.adv[1]), .raddr0(addr_a), .raddr1(addr_a + AW'(1)),
		.rdata0(pa0_s2), .rdata1(pa1_s2)
	);

	perl_ram #(.ADDR_W(AW), .DATA_W(DW)) u_tab_yb (
		.clk(clk), .we(ctl.wr[1]), .waddr(idx_s1), .wdata(val_s1),
		.re(ctl.adv[1]), .raddr0(addr_b), .raddr1(addr_b + AW'(1)),
		.rdata0(pb0_s2), .rdata1(pb1_s2)
	);

	// stage 3: corner hashes, near face on port 0 and far face on port 1
	assign base[0] = AW'(pa0_s2) + z_s2;
	assign base[1] = AW'(pb0_s2) + z_s2;
	assign base[2] = AW'(pa1_s2) + z_s2;
	assign base[3] = AW'(pb1_s2) + z_s2;

	for (genvar j = 0; j < 4; j++) begin : g_corner
		perl_ram #(.ADDR_W(AW), .DATA_W(DW)) u_tab_z (
			.clk(clk), .we(ctl.wr[2]), .waddr(idx_s2), .wdata(val_s2),
			.re(ctl.adv[2]), .raddr0(base[j]), .raddr1(base[j] + AW'(1)),
			.rdata0(lo_s3[j]), .rdata1(hi_s3[j])
		);
		assign corner_hash_s3[j] = lo_s3[j][perl_pkg::HASH_W-1:0];
		assign corner_hash_s3[j+4] = hi_s3[j][perl_pkg::HASH_W-1:0];
	end

endmodule

### rtl/core/perl_fade.sv
module perl_fade (
	input  logic                               clk,
	input  perl_pkg::pipe_ctl_t                ctl,
	input  logic [perl_pkg::FRAC_BITS-1:0]     frac,
	output logic [perl_pkg::FRAC_BITS-1:0]     frac_s3,
	output logic [perl_pkg::FADE_W-1:0]        fade_s4
);

	localparam int F = perl_pkg::FRAC_BITS;

	logic [F-1:0] t_s1, t_s2;
	logic [F:0]   t2_s2, t3_s3;
	logic [F+3:0] q_s3;
	logic [2*F:0] sq;
	logic [2*F+1:0] cu;
	logic [F+5:0] qs;
	logic [2*F+5:0] pr;
	logic [F+5:0] fr;

	// t^2 and t^3, each rounded back to F fraction bits
	assign sq = (2*F+1)'(t_s1) * (2*F+1)'(t_s1) + (2*F+1)'(perl_pkg::HALF_F);
	assign cu = (2*F+2)'(t2_s2) * (2*F+2)'(t_s2) + (2*F+2)'(perl_pkg::HALF_F);
	// 10 - 15t + 6t^2, wraps into two's complement
	assign qs = ((F+6)'(perl_pkg::FADE_C10) << F)
		- (F+6)'(perl_pkg::FADE_C15) * (F+6)'(t_s2)
		+ (F+6)'(perl_pkg::FADE_C6) * (F+6)'(t2_s2);
	assign pr = (2*F+6)'(t3_s3) * (2*F+6)'(q_s3) + (2*F+6)'(perl_pkg::HALF_F);
	assign fr = pr[2*F+5:F];

	always_ff @(posedge clk) begin
		if (ctl.adv[0])
			t_s1 <= frac;
		if (ctl.adv[1]) begin
			t_s2 <= t_s1;
			t2_s2 <= sq[2*F:F];
		end
		if (ctl.adv[2]) begin
			frac_s3 <= t_s2;
			t3_s3 <= cu[2*F:F];
			q_s3 <= qs[F+5] ? '0 : qs[F+3:0];
		end
		if (ctl.adv[3])
			fade_s4 <= (fr > (F+6)'(perl_pkg::ONE_F)) ? (F+1)'(perl_pkg::ONE_F) : fr[F:0];
	end

endmodule

### rtl/core/perl_blend.sv
module perl_blend (
	input  logic                                               clk,
	input  perl_pkg::pipe_ctl_t                                ctl,
	input  logic [perl_pkg::CORNERS-1:0][perl_pkg::HASH_W-1:0] corner_hash_s3,
	input  logic [perl_pkg::FRAC_BITS-1:0]                     fx_s3,
	input  logic [perl_pkg::FRAC_BITS-1:0]                     fy_s3,
	input  logic [perl_pkg::FRAC_BITS-1:0]                     fz_s3,
	input  logic [perl_pkg::FADE_W-1:0]                        u_s4,
	input  logic [perl_pkg::FADE_W-1:0]                        v_s4,
	input  logic [perl_pkg::FADE_W-1:0]                        w_s4,
	output logic [perl_pkg::NOISE_W-1:0]                       noise_s8
);

	localparam int F = perl_pkg::FRAC_BITS;
	localparam int OW = perl_pkg::OFS_W;
	localparam int GW = perl_pkg::GRAD_W;
	localparam int LW = perl_pkg::LERP_W;
	localparam int SW = LW + perl_pkg::NOISE_W;

	logic signed [OW-1:0] xo [2];
	logic signed [OW-1:0] yo [2];
	logic signed [OW-1:0] zo [2];
	logic signed [GW-1:0] g_s4 [perl_pkg::CORNERS];
	logic [perl_pkg::FADE_W-1:0] v_s5, w_s5, w_s6;
	logic signed [LW-1:0] e_s5 [4];
	logic signed [LW-1:0] zlo_s6, zhi_s6;
	logic signed [LW-1:0] n_s7;
	logic signed [LW:0] s;
	logic [SW-1:0] r;

	assign xo[0] = $signed({1'b0, fx_s3});
	assign yo[0] = $signed({1'b0, fy_s3});
	assign zo[0] = $signed({1'b0, fz_s3});
	assign xo[1] = xo[0] - OW'(perl_pkg::ONE_F);
	assign yo[1] = yo[0] - OW'(perl_pkg::ONE_F);
	assign zo[1] = zo[0] - OW'(perl_pkg::ONE_F);

	// remap to (n+1)/2, clamp below and saturate above
	assign s = (LW+1)'(n_s7) + (LW+1)'(perl_pkg::ONE_F);
	assign r = s[LW] ? '0
		: ((SW'(s) * SW'(perl_pkg::OUT_SCALE) + SW'(perl_pkg::HALF_F)) >> F);

	always_ff @(posedge clk) begin
		if (ctl.adv[3]) begin
			for (int c = 0; c < perl_pkg::CORNERS; c++)
				g_s4[c] <= perl_pkg::grad(corner_hash_s3[c], xo[c%2], yo[(c/2)%2], zo[c/4]);
		end
		if (ctl.adv[4]) begin
			for (int k = 0; k < 4; k++)
				e_s5[k] <= perl_pkg::lerp(u_s4, LW'(g_s4[2*k]), LW'(g_s4[2*k+1]));
			v_s5 <= v_s4;
			w_s5 <= w_s4;
		end
		if (ctl.adv[5]) begin
			zlo_s6 <= perl_pkg::lerp(v_s5, e_s5[0], e_s5[1]);
			zhi_s6 <= perl_pkg::lerp(v_s5, e_s5[2], e_s5[3]);
			w_s6 <= w_s5;
		end
		if (ctl.adv[6])
			n_s7 <= perl_pkg::lerp(w_s6, zlo_s6, zhi_s6);
		if (ctl.adv[7])
			noise_s8 <= (r > SW'(perl_pkg::NOISE_MAX)) ? perl_pkg::NOISE_W'(perl_pkg::NOISE_MAX)
				: r[perl_pkg::NOISE_W-1:0];
	end

endmodule

### rtl/core/perl_check.sv
module perl_check (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         item_valid,
	input logic                         item_ready,
	input logic                         operation,
	input logic                         noise_valid,
	input logic                         noise_ready,
	input logic [perl_pkg::NOISE_W-1:0] noise_value
);

	localparam int CW = $clog2(perl_pkg::N_STAGES + 1);

	logic [CW-1:0] pend_q;
	logic in_eval, out_take;

	assign in_eval = item_valid && item_ready && operation == perl_pkg::OP_EVAL;
	assign out_take = noise_valid && noise_ready;

	// count evaluations accepted and not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			pend_q <= '0;
		else if (in_eval && !out_take)
			pend_q <= pend_q + CW'(1);
		else if (!in_eval && out_take)
			pend_q <= pend_q - CW'(1);
	end

	a_no_invented: assert property (@(posedge clk) disable iff (!arst_n)
		noise_valid |-> pend_q != '0)
		else $error("result without a pending evaluation");

	a_depth: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q <= CW'(perl_pkg::N_STAGES))
		else $error("more evaluations in flight than pipeline stages");

	a_stall_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		!item_ready |-> noise_valid && !noise_ready)
		else $error("input stalled while output is free");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		noise_valid && !noise_ready |=> noise_valid && $stable(noise_value))
		else $error("stalled result dropped or changed");

endmodule

bind perlin_noise_3d_unit perl_check u_check (.*);

### dv/perlin_noise_3d_unit_test.sv
module perlin_noise_3d_unit_test;
	timeunit 1ns;
	timeprecision 1ps;

	// Scoreboard: holds its own copy of the permutation table and the queue of
	// expected noise values; evaluates the fixed-point noise for each accepted
	// evaluation item.
	class noise_scoreboard;
		byte unsigned perm[256];
		longint unsigned expected_noise[$];
		int mismatches;
		int checked;

		function longint round_shift(longint p);
			longint q;
			q = p + perl_pkg::HALF_F;
			if (q >= 0)
				return q >>> perl_pkg::FRAC_BITS;
			return -(((-q) + perl_pkg::ONE_F - 1) >>> perl_pkg::FRAC_BITS);
		endfunction

		function longint fade_curve(longint t);
			longint t2, q, t3, f;
			t2 = round_shift(t * t);
			q = perl_pkg::FADE_C10 * perl_pkg::ONE_F - perl_pkg::FADE_C15 * t
				+ perl_pkg::FADE_C6 * t2;
			if (q < 0)
				q = 0;
			t3 = round_shift(t2 * t);
			f = round_shift(t3 * q);
			if (f < 0)
				f = 0;
			if (f > perl_pkg::ONE_F)
				f = perl_pkg::ONE_F;
			return f;
		endfunction

		function longint blend(longint w, longint a, longint b);
			return a + round_shift((b - a) * w);
		endfunction

		function longint gradient_dot(int hcode, longint x, longint y, longint z);
			int h;
			longint u, v;
			h = hcode & 15;
			u = (h < 8) ? x : y;
			v = (h < 4) ? y : ((h == 12 || h == 14) ? x : z);
			return ((h & 1) ? -u : u) + ((h & 2) ? -v : v);
		endfunction

		function int lookup(int i);
			return perm[i & 255];
		endfunction

		function longint unsigned noise_at(logic [perl_pkg::COORD_W-1:0] cx,
				logic [perl_pkg::COORD_W-1:0] cy, logic [perl_pkg::COORD_W-1:0] cz);
			int xi, yi, zi, a, aa, ab, b, ba, bb;
			longint x, y, z, x1, y1, z1, u, v, w, n0, n1, f0, f1, zl, zh, n, s;
			longint unsigned r;
			xi = cx[perl_pkg::COORD_W-1:perl_pkg::FRAC_BITS];
			yi = cy[perl_pkg::COORD_W-1:perl_pkg::FRAC_BITS];
			zi = cz[perl_pkg::COORD_W-1:perl_pkg::FRAC_BITS];
			x = cx[perl_pkg::FRAC_BITS-1:0];
			y = cy[perl_pkg::FRAC_BITS-1:0];
			z = cz[perl_pkg::FRAC_BITS-1:0];
			x1 = x - perl_pkg::ONE_F;
			y1 = y - perl_pkg::ONE_F;
			z1 = z - perl_pkg::ONE_F;
			u = fade_curve(x);
			v = fade_curve(y);
			w = fade_curve(z);
			a = (lookup(xi) + yi) & 255;
			aa = (lookup(a) + zi) & 255;
			ab = (lookup(a + 1) + zi) & 255;
			b = (lookup(xi + 1) + yi) & 255;
			ba = (lookup(b) + zi) & 255;
			bb = (lookup(b + 1) + zi) & 255;
			n0 = blend(u, gradient_dot(lookup(aa), x, y, z), gradient_dot(lookup(ba), x1, y, z));
			n1 = blend(u, gradient_dot(lookup(ab), x, y1, z),
				gradient_dot(lookup(bb), x1, y1, z));
			zl = blend(v, n0, n1);
			f0 = blend(u, gradient_dot(lookup(aa + 1), x, y, z1),
				gradient_dot(lookup(ba + 1), x1, y, z1));
			f1 = blend(u, gradient_dot(lookup(ab + 1), x, y1, z1),
				gradient_dot(lookup(bb + 1), x1, y1, z1));
			zh = blend(v, f0, f1);
			n = blend(w, zl, zh);
			s = n + perl_pkg::ONE_F;
			if (s < 0)
				s = 0;
			r = (longint'(s) * perl_pkg::OUT_SCALE + perl_pkg::HALF_F) >> perl_pkg::FRAC_BITS;
			if (r > perl_pkg::NOISE_MAX)
				r = perl_pkg::NOISE_MAX;
			return r;
		endfunction

		function void note_item(logic op, logic [perl_pkg::COORD_W-1:0] cx,
				logic [perl_pkg::COORD_W-1:0] cy, logic [perl_pkg::COORD_W-1:0] cz,
				logic [perl_pkg::IDX_W-1:0] idx, logic [perl_pkg::ENT_W-1:0] val);
			if (op == perl_pkg::OP_LOAD) begin
				perm[idx] = val;
			end else begin
				expected_noise.push_back(noise_at(cx, cy, cz));
			end
		endfunction

		function void check_noise(logic [perl_pkg::NOISE_W-1:0] got);
			longint unsigned exp_val;
			checked++;
			if (expected_noise.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("MISMATCH: unexpected noise_value %0d", got);
				return;
			end
			exp_val = expected_noise.pop_front();
			if (got !== exp_val[perl_pkg::NOISE_W-1:0]) begin
				mismatches++;
				if (mismatches <= 10)
					$display("MISMATCH: noise_value expected %0d actual %0d", exp_val, got);
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic item_valid;
	logic item_ready;
	logic operation;
	logic [perl_pkg::COORD_W-1:0] coord_x, coord_y, coord_z;
	logic [perl_pkg::IDX_W-1:0] entry_index;
	logic [perl_pkg::ENT_W-1:0] entry_value;
	logic noise_valid;
	logic noise_ready;
	logic [perl_pkg::NOISE_W-1:0] noise_value;

	perlin_noise_3d_unit dut (
		.clk(clk), .arst_n(arst_n),
		.item_valid(item_valid), .item_ready(item_ready),
		.operation(operation), .coord_x(coord_x), .coord_y(coord_y), .coord_z(coord_z),
		.entry_index(entry_index), .entry_value(entry_value),
		.noise_valid(noise_valid), .noise_ready(noise_ready), .noise_value(noise_value)
	);

	noise_scoreboard board;
	longint cycle_count;
	bit sender_calm;      // no more idling on the input side
	bit receiver_calm;    // no more stalls on the output side
	bit long_holdoff;     // request a long receiver stall
	int evals_sent, loads_sent;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Limit the run: a hung run stops with a timeout report.
	initial begin
		cycle_count = 0;
		forever begin
			@(posedge clk);
			cycle_count++;
			if (cycle_count > 400000) begin
				$display("Timeout after %0d cycles", cycle_count);
				$display("Testbench completed WITH ERRORS");
				$finish;
			end
		end
	end

	// Watch the output: sample the handshake at the edge, before any update lands.
	always @(posedge clk) begin
		if (arst_n && noise_valid && noise_ready)
			board.check_noise(noise_value);
	end

	// Drive noise_ready: random stall bursts, one long hold-off on request, none at the end.
	initial begin
		int burst;
		noise_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (long_holdoff) begin
				noise_ready <= 1'b0;
				repeat (60) @(posedge clk);
				long_holdoff = 1'b0;
				noise_ready <= 1'b1;
			end else if (!receiver_calm && $urandom_range(0, 5) == 0) begin
				burst = $urandom_range(1, 11);
				noise_ready <= 1'b0;
				repeat (burst - 1) @(posedge clk);
			end else begin
				noise_ready <= 1'b1;
				// hold ready high for a while so stretches without stalls occur
				repeat ($urandom_range(0, 8)) @(posedge clk);
			end
		end
	end

	// Offer one item and hold it until accepted; an optional idle burst comes first.
	task automatic send_item(logic op, logic [perl_pkg::COORD_W-1:0] cx,
			logic [perl_pkg::COORD_W-1:0] cy, logic [perl_pkg::COORD_W-1:0] cz,
			logic [perl_pkg::IDX_W-1:0] idx, logic [perl_pkg::ENT_W-1:0] val);
		if (!sender_calm && $urandom_range(0, 7) == 0) begin
			item_valid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
		item_valid <= 1'b1;
		operation <= op;
		coord_x <= cx;
		coord_y <= cy;
		coord_z <= cz;
		entry_index <= idx;
		entry_value <= val;
		do
			@(posedge clk);
		while (!item_ready);
		board.note_item(op, cx, cy, cz, idx, val);
		if (op == perl_pkg::OP_LOAD)
			loads_sent++;
		else
			evals_sent++;
	endtask

	// Evaluation with random coordinates; random noise rides in the unused fields.
	task automatic send_eval(logic [perl_pkg::COORD_W-1:0] cx,
			logic [perl_pkg::COORD_W-1:0] cy, logic [perl_pkg::COORD_W-1:0] cz);
		send_item(perl_pkg::OP_EVAL, cx, cy, cz, perl_pkg::IDX_W'($urandom),
			perl_pkg::ENT_W'($urandom));
	endtask

	task automatic send_load(int idx, int val);
		send_item(perl_pkg::OP_LOAD, perl_pkg::COORD_W'($urandom),
			perl_pkg::COORD_W'($urandom), perl_pkg::COORD_W'($urandom),
			perl_pkg::IDX_W'(idx), perl_pkg::ENT_W'(val));
	endtask

	function automatic logic [perl_pkg::COORD_W-1:0] rand_coord();
		case ($urandom_range(0, 5))
			0: return {8'($urandom), 16'h0000};
			1: return {8'($urandom), 16'hFFFF};
			2: return {8'($urandom), 16'h8000 ^ 16'($urandom_range(0, 3))};
			default: return perl_pkg::COORD_W'($urandom);
		endcase
	endfunction

	// Wait until every expected result has arrived.
	task automatic drain();
		item_valid <= 1'b0;
		while (board.expected_noise.size() != 0)
			@(posedge clk);
	endtask

	// Load the whole table with a random permutation, or with an arbitrary fill.
	task automatic load_table(bit as_perm);
		int vals[256];
		int order[256];
		int j, t;
		for (int i = 0; i < 256; i++) begin
			vals[i] = as_perm ? i : $urandom_range(0, 255);
			order[i] = i;
		end
		for (int i = 255; i > 0; i--) begin
			j = $urandom_range(0, i);
			t = vals[i]; vals[i] = vals[j]; vals[j] = t;
			j = $urandom_range(0, i);
			t = order[i]; order[i] = order[j]; order[j] = t;
		end
		for (int i = 0; i < 256; i++)
			send_load(order[i], vals[i]);
	endtask

	initial begin
		board = new();
		sender_calm = 1'b0;
		receiver_calm = 1'b0;
		long_holdoff = 1'b0;
		evals_sent = 0;
		loads_sent = 0;
		arst_n = 1'b0;
		item_valid = 1'b0;
		operation = perl_pkg::OP_EVAL;
		coord_x = '0;
		coord_y = '0;
		coord_z = '0;
		entry_index = '0;
		entry_value = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Fill the table first: every entry, in random order, including values 0 and 255.
		load_table(1'b1);

		// Directed points: lattice corners, fraction extremes, wrap of the lattice part.
		send_eval(24'h000000, 24'h000000, 24'h000000);
		send_eval(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
		send_eval(24'h00FFFF, 24'h00FFFF, 24'h00FFFF);
		send_eval(24'hFF0000, 24'hFF0000, 24'hFF0000);
		send_eval(24'h008000, 24'h008000, 24'h008000);
		send_eval(24'h000001, 24'hFFFFFE, 24'h7F8001);
		send_eval(24'hFF8000, 24'h000000, 24'hFFFFFF);
		send_eval(24'h123456, 24'hABCDEF, 24'h555555);
		send_eval(24'hAAAAAA, 24'h555555, 24'h00FFFF);
		send_eval(24'hFFFFFF, 24'h000000, 24'h008000);

		// Hold off the receiver while items keep flowing so the pipeline backs up.
		long_holdoff = 1'b1;
		repeat (40)
			send_eval(rand_coord(), rand_coord(), rand_coord());

		// Pause the sender until every result is back.
		drain();

		// Random part: mostly evaluations, with single loads and one full rewrite.
		for (int k = 0; k < 800; k++) begin
			if (k > 690) begin
				sender_calm = 1'b1;
				receiver_calm = 1'b1;
			end
			if (k == 400)
				load_table(1'b0);
			if ($urandom_range(0, 9) == 0)
				send_load($urandom_range(0, 255), $urandom_range(0, 255));
			else
				send_eval(rand_coord(), rand_coord(), rand_coord());
		end

		drain();
		repeat (4 * perl_pkg::N_STAGES) @(posedge clk);
		$display("Run covered table fills, lattice and fraction corners, a long output stall");
		$display("and random traffic with table rewrites: %0d evaluations, %0d loads, %0d checked.",
			evals_sent, loads_sent, board.checked);
		if (board.mismatches == 0 && board.expected_noise.size() == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("%0d mismatches, %0d results outstanding", board.mismatches,
				board.expected_noise.size());
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
